// ----- hdl/psep_pkg.sv -----
// shared types and constants for the trace-byte event parser
// no dependencies; imported by psep_parser and the top level
`default_nettype none

package psep_pkg;

  localparam logic [7:0] BYTE_EXT  = 8'h02;
  localparam logic [7:0] BYTE_CBR  = 8'h03;
  localparam logic [7:0] PKT_MASK  = 8'h1F;
  localparam logic [7:0] PKT_CODE  = 8'h12;
  localparam logic [1:0] OP_PUSH   = 2'h0;
  localparam logic [1:0] OP_POP    = 2'h3;
  localparam int         OP_SHIFT  = 30;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_EXT     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_POP     = 2'd1,
    KIND_INVALID = 2'd2
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [31:0] addr;
    logic [1:0]  bad_op;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/ptwrite_packet_stack_event_parser.sv -----
// top level of the trace-byte stack event parser
// depends on psep_pkg and psep_parser
//
// usage:
//   in_ channel carries one raw trace byte per transaction (in_trace_byte).
//   out_ channel carries one stack event per complete write packet:
//   out_event_kind (push, pop, invalid opcode), out_stack_address and
//   out_bad_opcode.
//   an item is taken at a clock edge where valid is high and stall is low.
// registers and throughput:
//   a byte is held in an input register, then is classified and any event is
//   written to the output register, which drives the out_ ports.
//   one byte per cycle is sustained; the only limit is the output register,
//   which stops the input only when it holds an event the receiver is
//   stalling and the byte being processed would produce another one.
// reset:
//   rst_n low returns the parser to idle with no partial packet and empties
//   both registers. a stalled event holds its payload until it is taken.
`default_nettype none

module ptwrite_packet_stack_event_parser
  import psep_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_trace_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_event_kind,
  output logic [31:0]      out_stack_address,
  output logic [1:0]       out_bad_opcode
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [31:0] out_addr_r;
  logic [1:0]  out_bad_r;

  result_t     res;
  logic        out_free;
  logic        s1_adv;
  logic        s1_take;

  assign out_free = !out_valid_r || !out_stall;
  // stage can move on if it makes no event or the output register has room
  assign s1_adv   = !res.valid || out_free;
  assign s1_take  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;

  psep_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_in (s1_byte_r),
    .take    (s1_take),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_byte_r <= in_trace_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_take && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && res.valid) begin
      out_kind_r <= res.kind;
      out_addr_r <= res.addr;
      out_bad_r  <= res.bad_op;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_stack_address = out_addr_r;
  assign out_bad_opcode    = out_bad_r;

endmodule

`default_nettype wire

// ----- hdl/psep_parser.sv -----
// packet phase tracker and payload assembler for the event parser
// depends on psep_pkg; result is combinational from current state and byte
`default_nettype none

module psep_parser
  import psep_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] byte_in,
  input  wire logic       take,
  output result_t         res
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] full_word;
  logic [1:0]  op;

  // bytes shift in from the top, so four of them land little-endian
  assign full_word = {byte_in, word_r[31:8]};
  assign op        = full_word[OP_SHIFT +: 2];

  // next state
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    word_nxt  = word_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (byte_in == BYTE_EXT) phase_nxt = PH_EXT;
      end
      PH_EXT: begin
        priority if ((byte_in & PKT_MASK) == PKT_CODE) begin
          phase_nxt = PH_PAYLOAD;
          count_nxt = 2'd0;
        end else if (byte_in == BYTE_CBR) begin
          phase_nxt = PH_SKIP;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_SKIP: begin
        phase_nxt = PH_IDLE;
      end
      PH_PAYLOAD: begin
        word_nxt  = full_word;
        count_nxt = count_r + 2'd1;
        if (count_r == 2'd3) phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    res.valid  = (phase_r == PH_PAYLOAD) && (count_r == 2'd3);
    res.kind   = KIND_INVALID;
    res.addr   = '0;
    res.bad_op = op;
    priority if (op == OP_PUSH) begin
      res.kind   = KIND_PUSH;
      res.addr   = full_word;
      res.bad_op = '0;
    end else if (op == OP_POP) begin
      res.kind   = KIND_POP;
      res.addr   = {2'b00, full_word[OP_SHIFT-1:0]};
      res.bad_op = '0;
    end else begin
      res.kind   = KIND_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= 2'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) word_r <= word_nxt;
  end

endmodule

`default_nettype wire

// ----- sim/ptwrite_packet_stack_event_parser_tb.sv -----
// self-checking bench for the trace-byte stack event parser: random byte streams in,
// predicted push, pop and invalid-opcode events compared against the out_ channel
// depends on psep_pkg and ptwrite_packet_stack_event_parser
module ptwrite_packet_stack_event_parser_tb;
  import psep_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned STREAM_ITEMS = 400;

  typedef struct {
    kind_t       kind;
    logic [31:0] addr;
    logic [1:0]  bad_op;
  } stack_evt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_trace_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [31:0] out_stack_address;
  logic [1:0]  out_bad_opcode;

  logic [7:0]  trace_stream[$];
  stack_evt_t  pending_events[$];
  stack_evt_t  want_evt;

  // parser state as predicted
  phase_t      pp_phase = PH_IDLE;
  logic [1:0]  pp_count = 2'd0;
  logic [31:0] pp_word = 32'd0;

  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap_left = 0;
  int unsigned stall_left = 0;
  logic [31:0] cyc = 32'd0;
  logic        calm_window;

  ptwrite_packet_stack_event_parser DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_trace_byte     (in_trace_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_stack_address (out_stack_address),
    .out_bad_opcode    (out_bad_opcode)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one window in four runs with no gaps on either side
  assign calm_window = (cyc[7:6] == 2'b11);

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_window) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic decode_trace_byte(input logic [7:0] b);
    logic [31:0] word;
    case (pp_phase)
      PH_IDLE: begin
        if (b == BYTE_EXT) pp_phase = PH_EXT;
      end
      PH_EXT: begin
        if ((b & PKT_MASK) == PKT_CODE) begin
          pp_phase = PH_PAYLOAD;
          pp_count = 2'd0;
          pp_word = 32'd0;
        end else if (b == BYTE_CBR) begin
          pp_phase = PH_SKIP;
        end else begin
          pp_phase = PH_IDLE;
        end
      end
      PH_SKIP: begin
        pp_phase = PH_IDLE;
      end
      default: begin
        // little-endian gather of the payload word
        word = pp_word | ({24'd0, b} << (8 * pp_count));
        if (pp_count != 2'd3) begin
          pp_word = word;
          pp_count = pp_count + 2'd1;
        end else begin
          pp_phase = PH_IDLE;
          pp_count = 2'd0;
          pp_word = 32'd0;
          case (word[31:OP_SHIFT])
            OP_PUSH: pending_events.push_back('{KIND_PUSH, word, 2'd0});
            OP_POP:  pending_events.push_back('{KIND_POP, {2'b00, word[29:0]}, 2'd0});
            default: pending_events.push_back('{KIND_INVALID, 32'd0, word[31:OP_SHIFT]});
          endcase
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    n_errors++;
    if (n_errors <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  task automatic add_packet(input logic [7:0] code, input logic [31:0] word);
    trace_stream.push_back(BYTE_EXT);
    trace_stream.push_back(code);
    for (int i = 0; i < 4; i++) trace_stream.push_back(word[8*i +: 8]);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap_left = 0;
    end else if (in_valid && in_stall) begin
      // hold the stalled transaction
    end else if (in_valid) begin
      decode_trace_byte(in_trace_byte);
      in_gap_left = pick_gap();
      if (in_gap_left == 0 && trace_stream.size() > 0) begin
        in_trace_byte <= trace_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
        if (in_gap_left > 0) in_gap_left--;
      end
    end else if (in_gap_left > 0) begin
      in_gap_left--;
    end else if (trace_stream.size() > 0) begin
      in_valid <= 1'b1;
      in_trace_byte <= trace_stream.pop_front();
    end
  end

  // monitor and result-side stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected transaction: kind %0d addr %h bad_op %0d",
                     out_event_kind, out_stack_address, out_bad_opcode);
        end else begin
          want_evt = pending_events.pop_front();
          if (out_event_kind !== want_evt.kind)
            note_mismatch("event_kind", 32'(want_evt.kind), 32'(out_event_kind));
          if (out_stack_address !== want_evt.addr)
            note_mismatch("stack_address", want_evt.addr, out_stack_address);
          if (out_bad_opcode !== want_evt.bad_op)
            note_mismatch("bad_opcode", 32'(want_evt.bad_op), 32'(out_bad_opcode));
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  // watchdog: cycles in which neither channel completes a transaction
  always @(posedge clk) begin
    cyc <= cyc + 32'd1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int unsigned counted;
    int unsigned packets;
    int unsigned pick;
    int unsigned n;
    logic [31:0] word;
    logic [2:0]  code_hi;

    // directed: pad in idle, 0x02 as extension byte, cbr skipping a 0x02
    trace_stream.push_back(8'h00);
    trace_stream.push_back(BYTE_EXT);
    trace_stream.push_back(BYTE_EXT);
    trace_stream.push_back(BYTE_EXT);
    trace_stream.push_back(BYTE_CBR);
    trace_stream.push_back(BYTE_EXT);
    // push of zero, pop of all ones, both invalid opcodes
    add_packet(PKT_CODE, 32'h0000_0000);
    add_packet({3'b111, PKT_CODE[4:0]}, 32'hFFFF_FFFF);
    add_packet({3'b010, PKT_CODE[4:0]}, 32'h4000_0000);
    add_packet({3'b100, PKT_CODE[4:0]}, 32'hBFFF_FFFF);

    counted = 0;
    packets = 0;
    while (counted < STREAM_ITEMS || packets < 48) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        code_hi = 3'($urandom_range(0, 7));
        word = $urandom;
        case ($urandom_range(0, 9))
          0: word = 32'd0;
          1: word = 32'hFFFF_FFFF;
          default: ;
        endcase
        word[31:30] = 2'($urandom_range(0, 3));
        add_packet({code_hi, PKT_CODE[4:0]}, word);
        counted += 6;
        packets++;
      end else if (pick < 78) begin
        trace_stream.push_back(BYTE_EXT);
        trace_stream.push_back(BYTE_CBR);
        trace_stream.push_back(8'($urandom_range(0, 255)));
        counted += 3;
      end else if (pick < 86) begin
        // extension with an arbitrary second byte
        trace_stream.push_back(BYTE_EXT);
        trace_stream.push_back(8'($urandom_range(0, 255)));
        counted += 2;
      end else if (pick < 92) begin
        // packet cut short, later bytes run on as payload
        code_hi = 3'($urandom_range(0, 7));
        trace_stream.push_back(BYTE_EXT);
        trace_stream.push_back({code_hi, PKT_CODE[4:0]});
        n = $urandom_range(0, 3);
        repeat (n) trace_stream.push_back(8'($urandom_range(0, 255)));
        counted += 2 + n;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) trace_stream.push_back(8'($urandom_range(0, 255)));
        counted += n;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while ((trace_stream.size() > 0 || in_valid || pending_events.size() > 0)
           && idle_cycles < QUIET_LIMIT)
      @(negedge clk);
    repeat (10) @(negedge clk);

    if (pending_events.size() > 0) begin
      $display("%0d expected transactions never arrived", pending_events.size());
      n_errors += pending_events.size();
    end
    if (n_errors == 0 && idle_cycles < QUIET_LIMIT) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- ptwrite_packet_stack_event_parser.f -----
hdl/psep_pkg.sv
hdl/psep_parser.sv
hdl/ptwrite_packet_stack_event_parser.sv
sim/ptwrite_packet_stack_event_parser_tb.sv
